// ===== hdl/asf_pkg.sv =====
// ----------------------------------------------------------------------------
// asf_pkg
// Shared widths, operation codes, shift modes and branch condition codes
// for the 16-bit execute unit with barrel shifter and status flags.
// ----------------------------------------------------------------------------
package asf_pkg;

   localparam int DataW   = 16;
   localparam int OpW     = 4;
   localparam int ModeW   = 3;
   localparam int AmtW    = 3;
   localparam int CtxW    = 2;
   localparam int StatusW = 4;
   localparam int CondW   = 4;
   localparam int SbufW   = 4;
   localparam int Banks   = 3;
   localparam int BankW   = 2;

   // ALU operation codes
   localparam logic [OpW-1:0] OP_ADD  = 4'd0;
   localparam logic [OpW-1:0] OP_ADC  = 4'd1;
   localparam logic [OpW-1:0] OP_SUB  = 4'd2;
   localparam logic [OpW-1:0] OP_SBC  = 4'd3;
   localparam logic [OpW-1:0] OP_CMP  = 4'd4;
   localparam logic [OpW-1:0] OP_NEG  = 4'd5;
   localparam logic [OpW-1:0] OP_XOR  = 4'd6;
   localparam logic [OpW-1:0] OP_LOAD = 4'd7;
   localparam logic [OpW-1:0] OP_OR   = 4'd8;
   localparam logic [OpW-1:0] OP_AND  = 4'd9;
   localparam logic [OpW-1:0] OP_TEST = 4'd10;
   localparam logic [OpW-1:0] OP_NONE = 4'd11;

   // Shifter modes
   localparam logic [ModeW-1:0] SH_NONE = 3'd0;
   localparam logic [ModeW-1:0] SH_ASR  = 3'd1;
   localparam logic [ModeW-1:0] SH_LSL  = 3'd2;
   localparam logic [ModeW-1:0] SH_LSR  = 3'd3;
   localparam logic [ModeW-1:0] SH_ROL  = 3'd4;
   localparam logic [ModeW-1:0] SH_ROR  = 3'd5;

   // Shift buffer banks
   localparam logic [BankW-1:0] BANK_NORMAL = 2'd0;
   localparam logic [BankW-1:0] BANK_IRQ    = 2'd1;
   localparam logic [BankW-1:0] BANK_FIQ    = 2'd2;

   // Branch condition codes
   localparam logic [CondW-1:0] CC_CC  = 4'd0;
   localparam logic [CondW-1:0] CC_CS  = 4'd1;
   localparam logic [CondW-1:0] CC_SC  = 4'd2;
   localparam logic [CondW-1:0] CC_SS  = 4'd3;
   localparam logic [CondW-1:0] CC_NE  = 4'd4;
   localparam logic [CondW-1:0] CC_EQ  = 4'd5;
   localparam logic [CondW-1:0] CC_PL  = 4'd6;
   localparam logic [CondW-1:0] CC_MI  = 4'd7;
   localparam logic [CondW-1:0] CC_NHI = 4'd8;
   localparam logic [CondW-1:0] CC_HI  = 4'd9;
   localparam logic [CondW-1:0] CC_NGT = 4'd10;
   localparam logic [CondW-1:0] CC_GT  = 4'd11;
   localparam logic [CondW-1:0] CC_GE  = 4'd12;
   localparam logic [CondW-1:0] CC_LT  = 4'd13;

   // Status bit positions
   localparam int ST_N = 3;
   localparam int ST_Z = 2;
   localparam int ST_S = 1;
   localparam int ST_C = 0;

endpackage

// ===== hdl/asf_ifs.sv =====
// ----------------------------------------------------------------------------
// asf request and response channels
// Valid/ready channels carrying one instruction and one execute result.
// ----------------------------------------------------------------------------
interface asf_req_if;
   logic                            valid;
   logic                            ready;
   logic [asf_pkg::OpW-1:0]         op;
   logic [asf_pkg::DataW-1:0]       operand_a;
   logic [asf_pkg::DataW-1:0]       operand_b;
   logic [asf_pkg::ModeW-1:0]       shift_mode;
   logic [asf_pkg::AmtW-1:0]        shift_amount;
   logic [asf_pkg::CtxW-1:0]        context_req;
   logic                            write_flags;
   logic [asf_pkg::StatusW-1:0]     status_in;
   logic [asf_pkg::CondW-1:0]       branch_cond;

   modport source (
      output valid, op, operand_a, operand_b, shift_mode, shift_amount,
             context_req, write_flags, status_in, branch_cond,
      input  ready
   );
   modport sink (
      input  valid, op, operand_a, operand_b, shift_mode, shift_amount,
             context_req, write_flags, status_in, branch_cond,
      output ready
   );
endinterface

interface asf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [asf_pkg::DataW-1:0]       result;
   logic                            result_write;
   logic [asf_pkg::StatusW-1:0]     status_out;
   logic                            branch_taken;

   modport source (
      output valid, result, result_write, status_out, branch_taken,
      input  ready
   );
   modport sink (
      input  valid, result, result_write, status_out, branch_taken,
      output ready
   );
endinterface

// ===== hdl/alu_shifter_flags_16bit_core.sv =====
// Pipeline: an accepted transaction is loaded into the input register, then,
//    when the result register is free or is taken, into the result register
//    that drives the response channel. Throughput: one transaction per cycle
//    unless the response sink stalls; the shift buffer bank is read and written
//    in the same cycle as the shift, so back-to-back items chain.
// Reset: synchronous, clears both stage valids and all three shift buffer
//    banks to zero.
// ----------------------------------------------------------------------------
// alu_shifter_flags_16bit_core
// Execute unit: barrel shift of operand B through a banked 4-bit shift
// buffer, ALU operation with N/Z/S/C flags, and branch condition check.
// ----------------------------------------------------------------------------
module alu_shifter_flags_16bit_core (
   input  logic             clock,
   input  logic             reset,
   asf_req_if.sink          req_ch,
   asf_rsp_if.source        rsp_ch
);

   // input register
   logic                              s1_valid_ff;
   logic [asf_pkg::OpW-1:0]           op_ff;
   logic [asf_pkg::DataW-1:0]         a_ff;
   logic [asf_pkg::DataW-1:0]         b_ff;
   logic [asf_pkg::ModeW-1:0]         mode_ff;
   logic [asf_pkg::AmtW-1:0]          amt_ff;
   logic [asf_pkg::CtxW-1:0]          ctx_ff;
   logic                              wf_ff;
   logic [asf_pkg::StatusW-1:0]       st_ff;
   logic [asf_pkg::CondW-1:0]         cc_ff;

   // result register
   logic                              s2_valid_ff;
   logic [asf_pkg::DataW-1:0]         res_ff;
   logic                              wr_ff;
   logic [asf_pkg::StatusW-1:0]       stout_ff;
   logic                              taken_ff;

   logic [asf_pkg::SbufW-1:0]         sbuf_ff [asf_pkg::Banks];

   logic                              accept;
   logic                              advance;
   logic                              s1_valid_in;
   logic                              s2_valid_in;

   logic [asf_pkg::BankW-1:0]         bank;
   logic [1:0]                        amt_m1;
   logic [2:0]                        sh_dist;
   logic [asf_pkg::SbufW-1:0]         sb;
   logic [19:0]                       v_hi;
   logic [19:0]                       v_lo;
   logic signed [19:0]                v_hi_s;
   logic [39:0]                       rot_l;
   logic [39:0]                       rot_r;
   logic [19:0]                       sh;
   logic [asf_pkg::DataW-1:0]         b_sh;
   logic [asf_pkg::SbufW-1:0]         sb_in;

   logic [asf_pkg::DataW-1:0]         bb;
   logic                              cin;
   logic [17:0]                       sum;
   logic [asf_pkg::DataW-1:0]         res_in;
   logic                              wr_in;
   logic [asf_pkg::StatusW-1:0]       stout_in;
   logic                              taken_in;
   logic                              fn, fz, fs, fc;

   // handshake: the result register frees up when the sink takes it
   assign advance      = s1_valid_ff && (!s2_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign s2_valid_in  = advance || (s2_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_ch.op;
         a_ff    <= req_ch.operand_a;
         b_ff    <= req_ch.operand_b;
         mode_ff <= req_ch.shift_mode;
         amt_ff  <= req_ch.shift_amount;
         ctx_ff  <= req_ch.context_req;
         wf_ff   <= req_ch.write_flags;
         st_ff   <= req_ch.status_in;
         cc_ff   <= req_ch.branch_cond;
      end
   end

   // ---------------------------------------------------------------- shifter
   assign bank    = ctx_ff[1] ? asf_pkg::BANK_FIQ
                              : (ctx_ff[0] ? asf_pkg::BANK_IRQ : asf_pkg::BANK_NORMAL);
   // distance 1..4; zero wraps to four
   assign amt_m1  = amt_ff[1:0] - 2'd1;
   assign sh_dist = {1'b0, amt_m1} + 3'd1;
   assign sb      = sbuf_ff[bank];
   assign v_hi    = {b_ff, sb};
   assign v_lo    = {sb, b_ff};
   assign v_hi_s  = v_hi;
   assign rot_l   = {v_lo, v_lo} << sh_dist;
   assign rot_r   = {v_hi, v_hi} >> sh_dist;

   always_comb begin
      sh    = 20'd0;
      b_sh  = b_ff;
      sb_in = sb;
      case (mode_ff)
         asf_pkg::SH_ASR: begin
            sh    = v_hi_s >>> sh_dist;
            b_sh  = sh[19:4];
            sb_in = sh[3:0];
         end
         asf_pkg::SH_LSL: begin
            sh    = v_lo << sh_dist;
            b_sh  = sh[15:0];
            sb_in = sh[19:16];
         end
         asf_pkg::SH_LSR: begin
            sh    = v_hi >> sh_dist;
            b_sh  = sh[19:4];
            sb_in = sh[3:0];
         end
         asf_pkg::SH_ROL: begin
            sh    = rot_l[39:20];
            b_sh  = sh[15:0];
            sb_in = sh[19:16];
         end
         asf_pkg::SH_ROR: begin
            sh    = rot_r[19:0];
            b_sh  = sh[19:4];
            sb_in = sh[3:0];
         end
         default: begin
            sh    = 20'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < asf_pkg::Banks; i++) begin
            sbuf_ff[i] <= '0;
         end
      end else if (advance) begin
         sbuf_ff[bank] <= sb_in;
      end
   end

   // -------------------------------------------------------------------- ALU
   always_comb begin
      bb  = b_sh;
      cin = 1'b0;
      if (op_ff == asf_pkg::OP_SUB || op_ff == asf_pkg::OP_SBC ||
          op_ff == asf_pkg::OP_CMP) begin
         bb = ~b_sh;
      end
      if (op_ff == asf_pkg::OP_ADC || op_ff == asf_pkg::OP_SBC) begin
         cin = st_ff[asf_pkg::ST_C];
      end else if (op_ff == asf_pkg::OP_SUB || op_ff == asf_pkg::OP_CMP) begin
         cin = 1'b1;
      end
   end

   // 18-bit sign-extended sum: bit 17 gives S, bit 16 of the plain sum gives C
   assign sum = {{2{a_ff[15]}}, a_ff} + {{2{bb[15]}}, bb} + {17'd0, cin};

   always_comb begin
      res_in   = '0;
      wr_in    = 1'b0;
      stout_in = st_ff;
      case (op_ff) inside
         asf_pkg::OP_ADD, asf_pkg::OP_ADC, asf_pkg::OP_SUB, asf_pkg::OP_SBC,
         asf_pkg::OP_CMP: begin
            res_in = sum[15:0];
            wr_in  = (op_ff != asf_pkg::OP_CMP);
            // carry out is the unsigned 17th bit of a + bb + cin
            if (wf_ff) begin
               stout_in = {sum[15], (sum[15:0] == 16'd0), sum[17],
                           ({1'b0, a_ff} + {1'b0, bb} + {16'd0, cin}) >> 16 != 17'd0};
            end
         end
         asf_pkg::OP_NEG, asf_pkg::OP_XOR, asf_pkg::OP_LOAD, asf_pkg::OP_OR,
         asf_pkg::OP_AND, asf_pkg::OP_TEST: begin
            case (op_ff)
               asf_pkg::OP_NEG:  res_in = (~b_sh) + 16'd1;
               asf_pkg::OP_XOR:  res_in = a_ff ^ b_sh;
               asf_pkg::OP_LOAD: res_in = b_sh;
               asf_pkg::OP_OR:   res_in = a_ff | b_sh;
               default:          res_in = a_ff & b_sh;
            endcase
            wr_in = (op_ff != asf_pkg::OP_TEST);
            if (wf_ff) begin
               stout_in = {res_in[15], (res_in == 16'd0),
                           st_ff[asf_pkg::ST_S], st_ff[asf_pkg::ST_C]};
            end
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   // ------------------------------------------------------ branch condition
   assign fn = st_ff[asf_pkg::ST_N];
   assign fz = st_ff[asf_pkg::ST_Z];
   assign fs = st_ff[asf_pkg::ST_S];
   assign fc = st_ff[asf_pkg::ST_C];

   always_comb begin
      unique case (cc_ff)
         asf_pkg::CC_CC:  taken_in = !fc;
         asf_pkg::CC_CS:  taken_in = fc;
         asf_pkg::CC_SC:  taken_in = !fs;
         asf_pkg::CC_SS:  taken_in = fs;
         asf_pkg::CC_NE:  taken_in = !fz;
         asf_pkg::CC_EQ:  taken_in = fz;
         asf_pkg::CC_PL:  taken_in = !fn;
         asf_pkg::CC_MI:  taken_in = fn;
         asf_pkg::CC_NHI: taken_in = !(!fz && fc);
         asf_pkg::CC_HI:  taken_in = !fz && fc;
         asf_pkg::CC_NGT: taken_in = !(!fz && !fs);
         asf_pkg::CC_GT:  taken_in = !fz && !fs;
         asf_pkg::CC_GE:  taken_in = (fn == fs);
         asf_pkg::CC_LT:  taken_in = (fn != fs);
         default:         taken_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff   <= res_in;
         wr_ff    <= wr_in;
         stout_ff <= stout_in;
         taken_ff <= taken_in;
      end
   end

   assign rsp_ch.valid        = s2_valid_ff;
   assign rsp_ch.result       = res_ff;
   assign rsp_ch.result_write = wr_ff;
   assign rsp_ch.status_out   = stout_ff;
   assign rsp_ch.branch_taken = taken_ff;

   // -------------------------------------------------------------- checks
   a_rsp_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(s2_valid_ff) |-> $past(advance))
      else $error("response appeared without an item leaving the input stage");

   a_cmp_no_write: assert property (@(posedge clock) disable iff (reset)
      advance && (op_ff == asf_pkg::OP_CMP || op_ff == asf_pkg::OP_TEST)
      |=> !wr_ff)
      else $error("compare or test flagged for write-back");

   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      advance && !wf_ff |=> stout_ff == $past(st_ff))
      else $error("status changed with flag update disabled");

   a_other_banks_hold: assert property (@(posedge clock) disable iff (reset)
      advance && bank == asf_pkg::BANK_NORMAL
      |=> $stable(sbuf_ff[1]) && $stable(sbuf_ff[2]))
      else $error("shift buffer bank not selected was disturbed");

   a_no_shift_hold: assert property (@(posedge clock) disable iff (reset)
      advance && mode_ff == asf_pkg::SH_NONE |=> $stable(sbuf_ff[0]) &&
      $stable(sbuf_ff[1]) && $stable(sbuf_ff[2]))
      else $error("shift buffer written without a shift");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 16-bit execute unit. Instructions are queued up
// front (a directed set, then random ones), driven through the request channel
// with random gaps, and each accepted instruction is run through a local model
// of the shifter, the shift buffer banks, the ALU and the branch test. Results
// taken from the response channel, under random stalls, are compared in order.
// ----------------------------------------------------------------------------
module tb_top;

   // Codes outside the named ranges; the unit must still handle them
   localparam logic [asf_pkg::OpW-1:0]   OP_RSVD12     = 4'd12;
   localparam logic [asf_pkg::OpW-1:0]   OP_RSVD15     = 4'd15;
   localparam logic [asf_pkg::ModeW-1:0] SH_RSVD6      = 3'd6;
   localparam logic [asf_pkg::ModeW-1:0] SH_RSVD7      = 3'd7;
   localparam logic [asf_pkg::CtxW-1:0]  CTX_FIQ_ALIAS = 2'd3;
   localparam logic [asf_pkg::CondW-1:0] CC_ALWAYS     = 4'd14;
   localparam logic [asf_pkg::CondW-1:0] CC_ALWAYS_ALT = 4'd15;

   localparam int RandomInstrs = 1250;
   localparam int DrainCycles  = 20;
   localparam int CycleLimit   = 600000;
   localparam int ReportLimit  = 10;

   typedef struct packed {
      logic [asf_pkg::OpW-1:0]     op;
      logic [asf_pkg::DataW-1:0]   operand_a;
      logic [asf_pkg::DataW-1:0]   operand_b;
      logic [asf_pkg::ModeW-1:0]   shift_mode;
      logic [asf_pkg::AmtW-1:0]    shift_amount;
      logic [asf_pkg::CtxW-1:0]    context_req;
      logic                        write_flags;
      logic [asf_pkg::StatusW-1:0] status_in;
      logic [asf_pkg::CondW-1:0]   branch_cond;
   } instr_type;

   typedef struct packed {
      logic [asf_pkg::DataW-1:0]   result;
      logic                        result_write;
      logic [asf_pkg::StatusW-1:0] status_out;
      logic                        branch_taken;
   } exec_rsp_type;

   logic clock;
   logic reset;

   asf_req_if req_ch ();
   asf_rsp_if rsp_ch ();

   alu_shifter_flags_16bit_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   instr_type                 instr_q [$];
   exec_rsp_type              due_results [$];
   logic [asf_pkg::SbufW-1:0] sbuf_bank [asf_pkg::Banks];
   int                        fail_count;
   int                        cycle_count;
   int                        req_gap;
   int                        req_calm;
   int                        rsp_gap;
   int                        rsp_calm;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, and now and then a calm stretch
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [asf_pkg::DataW-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         4:       return 16'h0001;
         default: return (asf_pkg::DataW)'($urandom);
      endcase
   endfunction

   // Shift, ALU and branch test for one instruction; advances the shift buffer
   function automatic exec_rsp_type execute_instr(input instr_type it);
      logic [asf_pkg::BankW-1:0]   bank;
      logic [asf_pkg::AmtW-1:0]    amt_m1;
      int                          sh_dist;
      logic [19:0]                 v;
      logic [19:0]                 sh;
      logic [asf_pkg::DataW-1:0]   b;
      logic [asf_pkg::DataW-1:0]   bb;
      logic [asf_pkg::DataW-1:0]   lres;
      logic [asf_pkg::SbufW-1:0]   sb;
      logic [asf_pkg::DataW:0]     sum;
      int                          ssum;
      logic                        cin;
      logic                        fn, fz, fs, fc;
      exec_rsp_type                r;

      bank    = it.context_req[1] ? asf_pkg::BANK_FIQ
                                  : (it.context_req[0] ? asf_pkg::BANK_IRQ
                                                       : asf_pkg::BANK_NORMAL);
      amt_m1  = it.shift_amount - 1'b1;
      sh_dist = int'(amt_m1[1:0]) + 1;
      b       = it.operand_b;
      sb      = sbuf_bank[bank];

      case (it.shift_mode)
         asf_pkg::SH_ASR: begin
            v = {b, sb};
            sh = $signed(v) >>> sh_dist;
            {b, sb} = sh;
         end
         asf_pkg::SH_LSL: begin
            v = {sb, b};
            sh = v << sh_dist;
            {sb, b} = sh;
         end
         asf_pkg::SH_LSR: begin
            v = {b, sb};
            sh = v >> sh_dist;
            {b, sb} = sh;
         end
         asf_pkg::SH_ROL: begin
            v = {sb, b};
            sh = (v << sh_dist) | (v >> (20 - sh_dist));
            {sb, b} = sh;
         end
         asf_pkg::SH_ROR: begin
            v = {b, sb};
            sh = (v >> sh_dist) | (v << (20 - sh_dist));
            {b, sb} = sh;
         end
         default: ;
      endcase
      sbuf_bank[bank] = sb;

      r.result       = '0;
      r.result_write = 1'b0;
      r.status_out   = it.status_in;

      case (it.op)
         asf_pkg::OP_ADD, asf_pkg::OP_ADC, asf_pkg::OP_SUB, asf_pkg::OP_SBC,
         asf_pkg::OP_CMP: begin
            bb = (it.op == asf_pkg::OP_ADD || it.op == asf_pkg::OP_ADC) ? b : ~b;
            if (it.op == asf_pkg::OP_ADC || it.op == asf_pkg::OP_SBC)
               cin = it.status_in[asf_pkg::ST_C];
            else cin = (it.op != asf_pkg::OP_ADD);
            sum  = {1'b0, it.operand_a} + {1'b0, bb} + (asf_pkg::DataW+1)'(cin);
            ssum = int'($signed(it.operand_a)) + int'($signed(bb)) + int'(cin);
            if (it.write_flags) begin
               r.status_out[asf_pkg::ST_N] = sum[asf_pkg::DataW-1];
               r.status_out[asf_pkg::ST_Z] = (sum[asf_pkg::DataW-1:0] == '0);
               r.status_out[asf_pkg::ST_S] = (ssum < 0);
               r.status_out[asf_pkg::ST_C] = sum[asf_pkg::DataW];
            end
            r.result       = sum[asf_pkg::DataW-1:0];
            r.result_write = (it.op != asf_pkg::OP_CMP);
         end
         asf_pkg::OP_NEG, asf_pkg::OP_XOR, asf_pkg::OP_LOAD, asf_pkg::OP_OR,
         asf_pkg::OP_AND, asf_pkg::OP_TEST: begin
            case (it.op)
               asf_pkg::OP_NEG:  lres = ~b + 1'b1;
               asf_pkg::OP_XOR:  lres = it.operand_a ^ b;
               asf_pkg::OP_LOAD: lres = b;
               asf_pkg::OP_OR:   lres = it.operand_a | b;
               default:          lres = it.operand_a & b;
            endcase
            // S and C are kept for logic ops
            if (it.write_flags) begin
               r.status_out[asf_pkg::ST_N] = lres[asf_pkg::DataW-1];
               r.status_out[asf_pkg::ST_Z] = (lres == '0);
            end
            r.result       = lres;
            r.result_write = (it.op != asf_pkg::OP_TEST);
         end
         default: ;
      endcase

      fn = it.status_in[asf_pkg::ST_N];
      fz = it.status_in[asf_pkg::ST_Z];
      fs = it.status_in[asf_pkg::ST_S];
      fc = it.status_in[asf_pkg::ST_C];
      case (it.branch_cond)
         asf_pkg::CC_CC:  r.branch_taken = !fc;
         asf_pkg::CC_CS:  r.branch_taken = fc;
         asf_pkg::CC_SC:  r.branch_taken = !fs;
         asf_pkg::CC_SS:  r.branch_taken = fs;
         asf_pkg::CC_NE:  r.branch_taken = !fz;
         asf_pkg::CC_EQ:  r.branch_taken = fz;
         asf_pkg::CC_PL:  r.branch_taken = !fn;
         asf_pkg::CC_MI:  r.branch_taken = fn;
         asf_pkg::CC_NHI: r.branch_taken = !(!fz && fc);
         asf_pkg::CC_HI:  r.branch_taken = !fz && fc;
         asf_pkg::CC_NGT: r.branch_taken = !(!fz && !fs);
         asf_pkg::CC_GT:  r.branch_taken = !fz && !fs;
         asf_pkg::CC_GE:  r.branch_taken = (fn == fs);
         asf_pkg::CC_LT:  r.branch_taken = (fn != fs);
         default:         r.branch_taken = 1'b1;
      endcase
      return r;
   endfunction

   task automatic queue_instr(input logic [asf_pkg::OpW-1:0] op,
                              input logic [asf_pkg::DataW-1:0] a,
                              input logic [asf_pkg::DataW-1:0] b,
                              input logic [asf_pkg::ModeW-1:0] mode,
                              input logic [asf_pkg::AmtW-1:0] amt,
                              input logic [asf_pkg::CtxW-1:0] ctx,
                              input logic wf, input logic [asf_pkg::StatusW-1:0] st,
                              input logic [asf_pkg::CondW-1:0] cc);
      instr_type it;
      it = '{op, a, b, mode, amt, ctx, wf, st, cc};
      instr_q.push_back(it);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            due_results.push_back(execute_instr(instr_q.pop_front()));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0 || instr_q.size() == 0) begin
               req_ch.valid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end else begin
               req_ch.valid        <= 1'b1;
               req_ch.op           <= instr_q[0].op;
               req_ch.operand_a    <= instr_q[0].operand_a;
               req_ch.operand_b    <= instr_q[0].operand_b;
               req_ch.shift_mode   <= instr_q[0].shift_mode;
               req_ch.shift_amount <= instr_q[0].shift_amount;
               req_ch.context_req  <= instr_q[0].context_req;
               req_ch.write_flags  <= instr_q[0].write_flags;
               req_ch.status_in    <= instr_q[0].status_in;
               req_ch.branch_cond  <= instr_q[0].branch_cond;
               req_gap = pick_gap(req_calm);
            end
         end
      end
   end

   // Response monitor and checker
   always @(posedge clock) begin
      exec_rsp_type got;
      exec_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.result, rsp_ch.result_write, rsp_ch.status_out,
                    rsp_ch.branch_taken};
            if (due_results.size() == 0) begin
               if (fail_count < ReportLimit)
                  $display("unexpected transaction: result %h write %b status %h branch %b",
                           got.result, got.result_write, got.status_out, got.branch_taken);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (got.result !== want.result || got.result_write !== want.result_write ||
                   got.status_out !== want.status_out ||
                   got.branch_taken !== want.branch_taken) begin
                  if (fail_count < ReportLimit)
                     $display("mismatch: result %h/%h write %b/%b status %h/%h branch %b/%b (exp/act)",
                              want.result, got.result, want.result_write, got.result_write,
                              want.status_out, got.status_out, want.branch_taken,
                              got.branch_taken);
                  fail_count++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_gap = pick_gap(rsp_calm);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("alu_shifter_flags_16bit_core verification failed");
         $finish;
      end
   end

   initial begin
      logic [asf_pkg::OpW-1:0]   op;
      logic [asf_pkg::ModeW-1:0] mode;
      logic [asf_pkg::AmtW-1:0]  amt;
      logic [asf_pkg::CtxW-1:0]  ctx;

      clock       = 1'b0;
      reset       = 1'b1;
      fail_count  = 0;
      cycle_count = 0;
      req_gap     = 0;
      req_calm    = 0;
      rsp_gap     = 0;
      rsp_calm    = 0;
      for (int k = 0; k < asf_pkg::Banks; k++) sbuf_bank[k] = '0;
      req_ch.valid        = 1'b0;
      req_ch.op           = asf_pkg::OP_NONE;
      req_ch.operand_a    = '0;
      req_ch.operand_b    = '0;
      req_ch.shift_mode   = asf_pkg::SH_NONE;
      req_ch.shift_amount = '0;
      req_ch.context_req  = asf_pkg::BANK_NORMAL;
      req_ch.write_flags  = 1'b0;
      req_ch.status_in    = '0;
      req_ch.branch_cond  = asf_pkg::CC_CC;
      rsp_ch.ready        = 1'b0;

      // Directed: carry, overflow, borrow, each op, reserved codes, each shift
      queue_instr(asf_pkg::OP_ADD, 16'hFFFF, 16'h0001, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h0, asf_pkg::CC_CC);
      queue_instr(asf_pkg::OP_ADD, 16'h7FFF, 16'h0001, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'hF, asf_pkg::CC_CS);
      queue_instr(asf_pkg::OP_ADC, 16'hFFFF, 16'hFFFF, asf_pkg::SH_NONE, 3'd2,
                  asf_pkg::BANK_IRQ, 1'b1, 4'h1, asf_pkg::CC_SC);
      queue_instr(asf_pkg::OP_SUB, 16'h0000, 16'h0001, asf_pkg::SH_NONE, 3'd3,
                  asf_pkg::BANK_FIQ, 1'b1, 4'h2, asf_pkg::CC_SS);
      queue_instr(asf_pkg::OP_SBC, 16'h8000, 16'h0001, asf_pkg::SH_NONE, 3'd4,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h0, asf_pkg::CC_NE);
      queue_instr(asf_pkg::OP_CMP, 16'h1234, 16'h1234, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h4, asf_pkg::CC_EQ);
      queue_instr(asf_pkg::OP_NEG, 16'h0000, 16'h8000, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h3, asf_pkg::CC_PL);
      queue_instr(asf_pkg::OP_NEG, 16'hFFFF, 16'h0000, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h8, asf_pkg::CC_MI);
      queue_instr(asf_pkg::OP_XOR, 16'hA5A5, 16'hA5A5, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'hB, asf_pkg::CC_NHI);
      queue_instr(asf_pkg::OP_LOAD, 16'h0000, 16'h8000, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h5, asf_pkg::CC_HI);
      queue_instr(asf_pkg::OP_OR, 16'hF0F0, 16'h0F0F, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h6, asf_pkg::CC_NGT);
      queue_instr(asf_pkg::OP_AND, 16'hFFFF, 16'h0000, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'hA, asf_pkg::CC_GT);
      queue_instr(asf_pkg::OP_TEST, 16'h8001, 16'h8000, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'hC, asf_pkg::CC_GE);
      queue_instr(asf_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h9, asf_pkg::CC_LT);
      queue_instr(OP_RSVD12, 16'hFFFF, 16'h0001, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h7, CC_ALWAYS);
      queue_instr(OP_RSVD15, 16'h0001, 16'hFFFF, asf_pkg::SH_NONE, 3'd1,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'hE, CC_ALWAYS_ALT);
      queue_instr(asf_pkg::OP_LOAD, 16'h0000, 16'h8000, asf_pkg::SH_ASR, 3'd4,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h0, asf_pkg::CC_CS);
      queue_instr(asf_pkg::OP_LOAD, 16'h0000, 16'hFFFF, asf_pkg::SH_LSL, 3'd1,
                  asf_pkg::BANK_IRQ, 1'b1, 4'h0, asf_pkg::CC_EQ);
      queue_instr(asf_pkg::OP_ADD, 16'h0001, 16'h1234, asf_pkg::SH_LSR, 3'd0,
                  asf_pkg::BANK_FIQ, 1'b1, 4'h0, asf_pkg::CC_MI);
      queue_instr(asf_pkg::OP_LOAD, 16'h0000, 16'h8001, asf_pkg::SH_ROL, 3'd5,
                  CTX_FIQ_ALIAS, 1'b1, 4'h0, asf_pkg::CC_GT);
      queue_instr(asf_pkg::OP_LOAD, 16'h0000, 16'h000F, asf_pkg::SH_ROR, 3'd7,
                  asf_pkg::BANK_NORMAL, 1'b1, 4'h0, asf_pkg::CC_LT);
      queue_instr(asf_pkg::OP_LOAD, 16'h0000, 16'hC3C3, SH_RSVD6, 3'd3,
                  asf_pkg::BANK_IRQ, 1'b1, 4'h0, asf_pkg::CC_SS);
      queue_instr(asf_pkg::OP_LOAD, 16'h0000, 16'h3C3C, SH_RSVD7, 3'd6,
                  asf_pkg::BANK_FIQ, 1'b1, 4'h0, asf_pkg::CC_NE);
      queue_instr(asf_pkg::OP_ADD, 16'hFFFF, 16'h0001, asf_pkg::SH_LSL, 3'd2,
                  asf_pkg::BANK_NORMAL, 1'b0, 4'hA, asf_pkg::CC_HI);

      // Random: bank kept for runs so that shifts chain through the buffer
      ctx = asf_pkg::BANK_NORMAL;
      for (int k = 0; k < RandomInstrs; k++) begin
         if ($urandom_range(0, 9) == 0)
            op = (asf_pkg::OpW)'($urandom_range(OP_RSVD12, OP_RSVD15));
         else op = (asf_pkg::OpW)'($urandom_range(asf_pkg::OP_ADD, asf_pkg::OP_NONE));
         if ($urandom_range(0, 9) < 8)
            mode = (asf_pkg::ModeW)'($urandom_range(asf_pkg::SH_NONE, asf_pkg::SH_ROR));
         else mode = (asf_pkg::ModeW)'($urandom_range(SH_RSVD6, SH_RSVD7));
         if ($urandom_range(0, 9) < 8) amt = (asf_pkg::AmtW)'($urandom_range(1, 4));
         else amt = (asf_pkg::AmtW)'($urandom);
         if ($urandom_range(0, 9) < 3) begin
            if ($urandom_range(0, 9) == 0) ctx = CTX_FIQ_ALIAS;
            else ctx = (asf_pkg::CtxW)'($urandom_range(asf_pkg::BANK_NORMAL,
                                                       asf_pkg::BANK_FIQ));
         end
         queue_instr(op, pick_operand(), pick_operand(), mode, amt, ctx,
                     ($urandom_range(0, 3) != 0), (asf_pkg::StatusW)'($urandom),
                     (asf_pkg::CondW)'($urandom));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (instr_q.size() != 0) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0 && due_results.size() == 0) begin
         $display("alu_shifter_flags_16bit_core verification clean");
      end else begin
         $display("alu_shifter_flags_16bit_core verification failed");
      end
      $finish;
   end

endmodule
